// ===== rtl/hsd_pkg.sv =====
// shared types and constants of the huffman stream decoder
package hsd_pkg;

    localparam int NODE_SLOTS_DEF  = 512;
    localparam int STACK_SLOTS_DEF = 256;
    localparam int DRAIN_MAX_DEF   = 64;

    localparam int IDX_W  = 9;
    localparam int NODE_W = 19;

    localparam logic [1:0] PH_FLAG = 2'd0;
    localparam logic [1:0] PH_LEAF = 2'd1;
    localparam logic [1:0] PH_WALK = 2'd2;
    localparam logic [1:0] PH_HALT = 2'd3;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] stream_byte;
    } hsd_item_t;

    typedef struct packed {
        logic      valid;
        hsd_item_t item;
    } hsd_head_t;

    typedef struct packed {
        logic [7:0] sym;
        logic       symv;
        logic       last;
        logic       fin;
        logic       err;
    } hsd_res_t;

endpackage

// ===== rtl/hsd_ifs.sv =====
// channel interfaces of the huffman stream decoder
interface hsd_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] stream_byte;
    modport source (output valid, output opcode, output stream_byte, input ready);
    modport sink (input valid, input opcode, input stream_byte, output ready);
endinterface

interface hsd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_symbol;
    logic       symbol_valid;
    logic       last_in_run;
    logic       finished;
    logic       tree_error;
    modport source (output valid, output out_symbol, output symbol_valid,
                    output last_in_run, output finished, output tree_error, input ready);
    modport sink (input valid, input out_symbol, input symbol_valid,
                  input last_in_run, input finished, input tree_error, output ready);
endinterface

interface hsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] symbol_total;
    modport source (output valid, output symbol_total, input ready);
    modport sink (input valid, input symbol_total, output ready);
endinterface

// ===== rtl/huffman_stream_decoder.sv =====
// a stream byte passes the back end as a pop, its bits and a result: a tree-load bit is handled in S_BIT,
// a walk bit is a node store read (S_BIT) then a child check (S_WDATA), and a stack pop adds S_POP
// a drain transaction gives one symbol per cycle while the result channel does not stall
// results leave through one output register; the node store's read port is registered
// reset: asynchronous, clears control state; node store and stack are not cleared
// and are only read where they have been written
module huffman_stream_decoder #(
    parameter int NODE_SLOTS  = hsd_pkg::NODE_SLOTS_DEF,
    parameter int STACK_SLOTS = hsd_pkg::STACK_SLOTS_DEF,
    parameter int DRAIN_MAX   = hsd_pkg::DRAIN_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    hsd_item_if.sink     item,
    hsd_result_if.source result,
    hsd_cfg_if.sink      cfg
);
    hsd_pkg::hsd_head_t head;
    logic               pop;

    hsd_front u_front (
        .clk(clk), .rst_n(rst_n), .item(item), .pop(pop), .head(head)
    );

    hsd_back #(
        .NODE_SLOTS(NODE_SLOTS), .STACK_SLOTS(STACK_SLOTS), .DRAIN_MAX(DRAIN_MAX)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .pop(pop), .result(result), .cfg(cfg)
    );
endmodule

// ===== rtl/hsd_ram.sv =====
// generic simple dual port ram with registered read
module hsd_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);
    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/hsd_front.sv =====
// input front: accepts items into a two-entry queue for the back end
module hsd_front (
    input  logic                clk,
    input  logic                rst_n,
    hsd_item_if.sink            item,
    input  logic                pop,
    output hsd_pkg::hsd_head_t  head
);
    hsd_pkg::hsd_item_t mem_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign item.ready = (cnt_reg != 2'd2);
    assign push = item.valid && item.ready;
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = ~wp_reg;
        end
        if (pop && head.valid)
        begin
            rp_next = ~rp_reg;
        end
        case ({push, pop && head.valid})
            2'b10: cnt_next = cnt_reg + 2'd1;
            2'b01: cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= {item.opcode, item.stream_byte};
        end
    end
endmodule

// ===== rtl/hsd_back.sv =====
// back end: tree load, tree walk, drain and result ordering
module hsd_back #(
    parameter int NODE_SLOTS  = hsd_pkg::NODE_SLOTS_DEF,
    parameter int STACK_SLOTS = hsd_pkg::STACK_SLOTS_DEF,
    parameter int DRAIN_MAX   = hsd_pkg::DRAIN_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hsd_pkg::hsd_head_t head,
    output logic               pop,
    hsd_result_if.source       result,
    hsd_cfg_if.sink            cfg
);
    localparam int NA  = $clog2(NODE_SLOTS);
    localparam int SA  = $clog2(STACK_SLOTS);
    localparam int NCW = $clog2(NODE_SLOTS + 1);
    localparam int SDW = $clog2(STACK_SLOTS + 1);
    localparam int DW  = $clog2(DRAIN_MAX + 1);
    localparam int IW  = hsd_pkg::IDX_W;
    localparam int NW  = hsd_pkg::NODE_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BIT   = 3'd1;
    localparam logic [2:0] S_POP   = 3'd2;
    localparam logic [2:0] S_WDATA = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;

    logic [2:0]       st_reg, st_next;
    logic [1:0]       phase_reg, phase_next;
    logic [2:0]       bitcnt_reg, bitcnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic [NCW-1:0]   ncount_reg, ncount_next;
    logic [SDW-1:0]   sdepth_reg, sdepth_next;
    logic [3:0]       leaf_left_reg, leaf_left_next;
    logic [7:0]       shift_reg, shift_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    root_reg, root_next;
    logic [31:0]      done_reg, done_next;
    logic             err_reg, err_next;
    logic [31:0]      total_reg, total_next;
    logic [DW-1:0]    drain_reg, drain_next;
    hsd_pkg::hsd_res_t pend_reg, pend_next;
    logic             pend_has_reg, pend_has_next;
    hsd_pkg::hsd_res_t out_reg, out_next;
    logic             out_v_reg, out_v_next;

    logic             nd_we, nd_re;
    logic [NA-1:0]    nd_waddr, nd_raddr;
    logic [NW-1:0]    nd_wdata, nd_rdata;
    logic             sk_we, sk_re;
    logic [SA-1:0]    sk_waddr, sk_raddr;
    logic [IW-1:0]    sk_wdata, sk_rdata;

    logic             bit_v, adv, prod, stall, out_free, out_load, hit;
    logic [31:0]      done_inc, remain;
    logic [IW-1:0]    cnt_idx, nx;
    logic [NCW-1:0]   nc_m1;
    logic [SDW-1:0]   sd_m1;
    logic [7:0]       shifted;
    logic [3:0]       left_dec;
    hsd_pkg::hsd_res_t prod_res, out_val, status;

    hsd_ram #(.W(NW), .DEPTH(NODE_SLOTS)) u_node_ram (
        .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .re(nd_re), .raddr(nd_raddr), .rdata(nd_rdata)
    );

    hsd_ram #(.W(IW), .DEPTH(STACK_SLOTS)) u_stack_ram (
        .clk(clk), .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
        .re(sk_re), .raddr(sk_raddr), .rdata(sk_rdata)
    );

    assign cfg.ready = 1'b1;
    assign result.valid = out_v_reg;
    assign result.out_symbol = out_reg.sym;
    assign result.symbol_valid = out_reg.symv;
    assign result.last_in_run = out_reg.last;
    assign result.finished = out_reg.fin;
    assign result.tree_error = out_reg.err;

    always_comb
    begin
        st_next = st_reg;
        phase_next = phase_reg;
        bitcnt_next = bitcnt_reg;
        byte_next = byte_reg;
        ncount_next = ncount_reg;
        sdepth_next = sdepth_reg;
        leaf_left_next = leaf_left_reg;
        shift_next = shift_reg;
        cur_next = cur_reg;
        done_next = done_reg;
        err_next = err_reg;
        total_next = cfg.valid ? cfg.symbol_total : total_reg;
        drain_next = drain_reg;
        pend_next = pend_reg;
        pend_has_next = pend_has_reg;
        out_next = out_reg;
        out_v_next = out_v_reg;
        pop = 1'b0;
        nd_we = 1'b0;
        nd_waddr = '0;
        nd_wdata = '0;
        nd_re = 1'b0;
        nd_raddr = '0;
        sk_we = 1'b0;
        sk_waddr = '0;
        sk_wdata = '0;
        sk_re = 1'b0;
        sk_raddr = '0;
        adv = 1'b0;
        prod = 1'b0;
        prod_res = '0;
        out_load = 1'b0;
        out_val = '0;

        bit_v = byte_reg[3'd7 - bitcnt_reg];
        done_inc = done_reg + 32'd1;
        hit = (done_inc >= total_reg);
        remain = total_reg - done_reg;
        out_free = !out_v_reg || result.ready;
        cnt_idx = IW'(ncount_reg);
        nc_m1 = ncount_reg - NCW'(1);
        sd_m1 = sdepth_reg - SDW'(1);
        shifted = {shift_reg[6:0], bit_v};
        left_dec = leaf_left_reg - 4'd1;
        nx = bit_v ? cur_reg[17:9] : cur_reg[8:0];
        if (32'(nx) >= NODE_SLOTS)
        begin
            nx = '0;
        end
        status = '0;
        status.last = 1'b1;
        status.fin = (phase_reg == hsd_pkg::PH_HALT) && !err_reg;
        status.err = err_reg;

        case (st_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    byte_next = head.item.stream_byte;
                    bitcnt_next = 3'd0;
                    st_next = S_END;
                    if (head.item.opcode == hsd_pkg::OP_BYTE)
                    begin
                        st_next = S_BIT;
                    end
                    else if (phase_reg == hsd_pkg::PH_WALK && root_reg[18])
                    begin
                        if (done_reg >= total_reg)
                        begin
                            phase_next = hsd_pkg::PH_HALT;
                        end
                        else
                        begin
                            drain_next = (remain > 32'(DRAIN_MAX)) ? DW'(DRAIN_MAX)
                                                                  : DW'(remain);
                            st_next = S_DRAIN;
                        end
                    end
                end
            end
            S_BIT:
            begin
                case (phase_reg)
                    hsd_pkg::PH_FLAG:
                    begin
                        adv = 1'b1;
                        if (ncount_reg == NCW'(NODE_SLOTS))
                        begin
                            err_next = 1'b1;
                            phase_next = hsd_pkg::PH_HALT;
                        end
                        else if (bit_v)
                        begin
                            nd_we = 1'b1;
                            nd_waddr = ncount_reg[NA-1:0];
                            nd_wdata = {1'b1, {(NW-1){1'b0}}};
                            ncount_next = ncount_reg + NCW'(1);
                            phase_next = hsd_pkg::PH_LEAF;
                            leaf_left_next = 4'd8;
                            shift_next = 8'd0;
                        end
                        else if (sdepth_reg == SDW'(STACK_SLOTS))
                        begin
                            err_next = 1'b1;
                            phase_next = hsd_pkg::PH_HALT;
                        end
                        else
                        begin
                            nd_we = 1'b1;
                            nd_waddr = ncount_reg[NA-1:0];
                            nd_wdata = {1'b0, {IW{1'b0}}, cnt_idx + IW'(1)};
                            ncount_next = ncount_reg + NCW'(1);
                            sk_we = 1'b1;
                            sk_waddr = sdepth_reg[SA-1:0];
                            sk_wdata = cnt_idx;
                            sdepth_next = sdepth_reg + SDW'(1);
                        end
                    end
                    hsd_pkg::PH_LEAF:
                    begin
                        shift_next = shifted;
                        leaf_left_next = left_dec;
                        if (left_dec != 4'd0)
                        begin
                            adv = 1'b1;
                        end
                        else
                        begin
                            nd_we = 1'b1;
                            nd_waddr = nc_m1[NA-1:0];
                            nd_wdata = {1'b1, 10'd0, shifted};
                            if (sdepth_reg == '0)
                            begin
                                adv = 1'b1;
                                cur_next = root_reg;
                                phase_next = (done_reg >= total_reg) ? hsd_pkg::PH_HALT
                                                                     : hsd_pkg::PH_WALK;
                            end
                            else
                            begin
                                // fetch the parent waiting for its right child
                                sk_re = 1'b1;
                                sk_raddr = sd_m1[SA-1:0];
                                sdepth_next = sd_m1;
                                st_next = S_POP;
                            end
                        end
                    end
                    hsd_pkg::PH_WALK:
                    begin
                        if (root_reg[18])
                        begin
                            adv = 1'b1;
                        end
                        else if (done_reg >= total_reg)
                        begin
                            phase_next = hsd_pkg::PH_HALT;
                            adv = 1'b1;
                        end
                        else
                        begin
                            nd_re = 1'b1;
                            nd_raddr = nx[NA-1:0];
                            st_next = S_WDATA;
                        end
                    end
                    default:
                    begin
                        adv = 1'b1;
                    end
                endcase
            end
            S_POP:
            begin
                nd_we = 1'b1;
                nd_waddr = sk_rdata[NA-1:0];
                nd_wdata = {1'b0, cnt_idx, sk_rdata + IW'(1)};
                phase_next = hsd_pkg::PH_FLAG;
                adv = 1'b1;
            end
            S_WDATA:
            begin
                if (nd_rdata[18])
                begin
                    prod = 1'b1;
                    prod_res.sym = nd_rdata[7:0];
                    prod_res.symv = 1'b1;
                    prod_res.fin = hit;
                    if (!(pend_has_reg && !out_free))
                    begin
                        done_next = done_inc;
                        cur_next = root_reg;
                        if (hit)
                        begin
                            phase_next = hsd_pkg::PH_HALT;
                        end
                        adv = 1'b1;
                    end
                end
                else
                begin
                    cur_next = nd_rdata;
                    adv = 1'b1;
                end
            end
            S_DRAIN:
            begin
                prod = 1'b1;
                prod_res.sym = root_reg[7:0];
                prod_res.symv = 1'b1;
                prod_res.fin = hit;
                if (!(pend_has_reg && !out_free))
                begin
                    done_next = done_inc;
                    if (hit)
                    begin
                        phase_next = hsd_pkg::PH_HALT;
                    end
                    drain_next = drain_reg - DW'(1);
                    if (drain_reg == DW'(1))
                    begin
                        st_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_val = status;
                    if (pend_has_reg)
                    begin
                        out_val = pend_reg;
                        out_val.last = 1'b1;
                    end
                    pend_has_next = 1'b0;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            if (bitcnt_reg == 3'd7)
            begin
                st_next = S_END;
            end
            else
            begin
                bitcnt_next = bitcnt_reg + 3'd1;
                st_next = S_BIT;
            end
        end

        // one symbol is held back so the final one of a transaction can be marked last
        stall = prod && pend_has_reg && !out_free;
        if (prod && !stall)
        begin
            if (pend_has_reg)
            begin
                out_load = 1'b1;
                out_val = pend_reg;
            end
            pend_next = prod_res;
            pend_has_next = 1'b1;
        end

        if (out_load)
        begin
            out_next = out_val;
            out_v_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_v_next = 1'b0;
        end

        root_next = root_reg;
        if (nd_we && nd_waddr == '0)
        begin
            root_next = nd_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            phase_reg <= hsd_pkg::PH_FLAG;
            bitcnt_reg <= 3'd0;
            ncount_reg <= '0;
            sdepth_reg <= '0;
            leaf_left_reg <= 4'd0;
            done_reg <= 32'd0;
            err_reg <= 1'b0;
            total_reg <= 32'd0;
            drain_reg <= '0;
            pend_has_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            phase_reg <= phase_next;
            bitcnt_reg <= bitcnt_next;
            ncount_reg <= ncount_next;
            sdepth_reg <= sdepth_next;
            leaf_left_reg <= leaf_left_next;
            done_reg <= done_next;
            err_reg <= err_next;
            total_reg <= total_next;
            drain_reg <= drain_next;
            pend_has_reg <= pend_has_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        shift_reg <= shift_next;
        cur_reg <= cur_next;
        root_reg <= root_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
    end
endmodule

// ===== rtl/hsd_checker.sv =====
// port checker of the huffman stream decoder and its bind
module hsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       r_valid,
    input logic       r_ready,
    input logic [7:0] r_sym,
    input logic       r_symv,
    input logic       r_last,
    input logic       r_fin,
    input logic       r_err
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable({r_sym, r_symv, r_last, r_fin, r_err}))
        else $error("result changed while stalled");

    a_fin_err: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid |-> !(r_fin && r_err))
        else $error("finished and tree error together");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_symv |-> r_sym == 8'd0 && r_last)
        else $error("status result malformed");

    a_err_nosym: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_err |-> !r_symv)
        else $error("symbol after tree error");
endmodule

bind huffman_stream_decoder hsd_checker u_hsd_checker (
    .clk(clk), .rst_n(rst_n),
    .r_valid(result.valid), .r_ready(result.ready),
    .r_sym(result.out_symbol), .r_symv(result.symbol_valid),
    .r_last(result.last_in_run), .r_fin(result.finished), .r_err(result.tree_error)
);

// ===== tb/huffman_stream_decoder_tb.sv =====
// self-checking testbench of the huffman stream decoder
module huffman_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 6000;
    localparam int SETTLE = 40;

    class decode_scoreboard;
        logic [18:0] node_mem [hsd_pkg::NODE_SLOTS_DEF];
        logic [8:0]  open_nodes [hsd_pkg::STACK_SLOTS_DEF];
        int unsigned n_nodes, n_open, leaf_left, sym_acc, cursor, emitted, total;
        logic [1:0]  ph;
        bit          err;
        hsd_pkg::hsd_res_t pending[$];
        int          mismatches;

        function void clear();
            n_nodes = 0; n_open = 0; leaf_left = 0; sym_acc = 0; cursor = 0;
            emitted = 0; total = 0; ph = hsd_pkg::PH_FLAG; err = 0; mismatches = 0;
            foreach (node_mem[i]) node_mem[i] = '0;
            foreach (open_nodes[i]) open_nodes[i] = '0;
        endfunction

        function void set_total(logic [31:0] v);
            total = v;
        endfunction

        function void emit(logic [7:0] s, logic v);
            hsd_pkg::hsd_res_t r;
            r.sym = s; r.symv = v; r.last = 1'b0;
            r.fin = (ph == hsd_pkg::PH_HALT) && !err;
            r.err = err;
            pending = {pending, r};
        endfunction

        function void halt_on_error();
            err = 1'b1;
            ph = hsd_pkg::PH_HALT;
        endfunction

        function void step_bit(logic b);
            int unsigned nxt;
            logic [18:0] cur;
            case (ph)
                hsd_pkg::PH_FLAG: begin
                    if (n_nodes >= hsd_pkg::NODE_SLOTS_DEF) begin
                        halt_on_error();
                    end
                    else if (b) begin
                        node_mem[n_nodes] = 19'h40000;
                        n_nodes++;
                        ph = hsd_pkg::PH_LEAF; leaf_left = 8; sym_acc = 0;
                    end
                    else if (n_open >= hsd_pkg::STACK_SLOTS_DEF) begin
                        halt_on_error();
                    end
                    else begin
                        node_mem[n_nodes] = (n_nodes + 1) & 9'h1ff;
                        open_nodes[n_open] = n_nodes;
                        n_nodes++; n_open++;
                    end
                end
                hsd_pkg::PH_LEAF: begin
                    sym_acc = ((sym_acc << 1) | b) & 8'hff;
                    leaf_left--;
                    if (leaf_left == 0) begin
                        node_mem[n_nodes - 1] = 19'h40000 | sym_acc;
                        if (n_open == 0) begin
                            ph = hsd_pkg::PH_WALK; cursor = 0;
                            if (emitted >= total) ph = hsd_pkg::PH_HALT;
                        end
                        else begin
                            n_open--;
                            node_mem[open_nodes[n_open]][17:9] = n_nodes & 9'h1ff;
                            ph = hsd_pkg::PH_FLAG;
                        end
                    end
                end
                hsd_pkg::PH_WALK: begin
                    if (!node_mem[0][18]) begin
                        if (emitted >= total) begin
                            ph = hsd_pkg::PH_HALT;
                        end
                        else begin
                            cur = node_mem[cursor];
                            nxt = b ? cur[17:9] : cur[8:0];
                            if (node_mem[nxt][18]) begin
                                emitted++; cursor = 0;
                                if (emitted >= total) ph = hsd_pkg::PH_HALT;
                                emit(node_mem[nxt][7:0], 1'b1);
                            end
                            else begin
                                cursor = nxt;
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void note_item(logic op, logic [7:0] data);
            int start_size;
            int unsigned cnt;
            start_size = pending.size();
            if (op == hsd_pkg::OP_BYTE) begin
                for (int k = 7; k >= 0; k--) step_bit(data[k]);
            end
            else if (ph == hsd_pkg::PH_WALK && node_mem[0][18]) begin
                if (emitted >= total) begin
                    ph = hsd_pkg::PH_HALT;
                end
                else begin
                    cnt = total - emitted;
                    if (cnt > hsd_pkg::DRAIN_MAX_DEF) cnt = hsd_pkg::DRAIN_MAX_DEF;
                    repeat (cnt) begin
                        emitted++;
                        if (emitted >= total) ph = hsd_pkg::PH_HALT;
                        emit(node_mem[0][7:0], 1'b1);
                    end
                end
            end
            if (pending.size() == start_size) emit(8'h00, 1'b0);
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check(hsd_pkg::hsd_res_t got);
            hsd_pkg::hsd_res_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    hsd_item_if   item ();
    hsd_result_if result ();
    hsd_cfg_if    cfg ();

    huffman_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    decode_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;
    int quiet_cycles;
    bit tree_bits[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver ready, with random stalls and an optional long hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            result.ready <= 1'b0;
        end
        else begin
            result.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        hsd_pkg::hsd_res_t got;
        if (rst_n) begin
            if (cfg.valid && cfg.ready) sb.set_total(cfg.symbol_total);
            if (item.valid && item.ready) sb.note_item(item.opcode, item.stream_byte);
            if (result.valid && result.ready) begin
                got.sym = result.out_symbol;
                got.symv = result.symbol_valid;
                got.last = result.last_in_run;
                got.fin = result.finished;
                got.err = result.tree_error;
                sb.check(got);
            end
            if ((item.valid && item.ready) || (result.valid && result.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic send_item(logic op, logic [7:0] data);
        if ($urandom_range(99) < tx_idle_pct) begin
            @(negedge clk);
            item.valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge clk);
        end
        @(negedge clk);
        item.valid <= 1'b1;
        item.opcode <= op;
        item.stream_byte <= data;
        do @(posedge clk); while (!item.ready);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_total(logic [31:0] v);
        wait_idle();
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.symbol_total <= v;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // preorder tree description with random shape and symbols, root always internal
    task automatic build_tree(int max_internal);
        int need;
        int internals;
        logic [7:0] s;
        need = 1; internals = 0;
        while (need > 0) begin
            if (internals == 0 || (internals < max_internal && $urandom_range(1))) begin
                tree_bits = {tree_bits, 1'b0};
                internals++; need++;
            end
            else begin
                tree_bits = {tree_bits, 1'b1};
                case ($urandom_range(3))
                    0: s = 8'h00;
                    1: s = 8'hff;
                    default: s = $urandom_range(255);
                endcase
                for (int k = 7; k >= 0; k--) tree_bits = {tree_bits, s[k]};
                need--;
            end
        end
    endtask

    task automatic random_items(int count);
        repeat (count) begin
            if ($urandom_range(99) < 8) send_item(hsd_pkg::OP_DRAIN, $urandom_range(255));
            else send_item(hsd_pkg::OP_BYTE, $urandom_range(255));
        end
    endtask

    initial
    begin
        logic [7:0] b;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        item.valid = 1'b0; item.opcode = hsd_pkg::OP_BYTE; item.stream_byte = '0;
        cfg.valid = 1'b0; cfg.symbol_total = '0;
        result.ready = 1'b0;
        tx_idle_pct = 15; rx_idle_pct = 75; rx_hold = 0; quiet_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_total(32'd0);
        build_tree(12);
        // drain request while the tree is still loading
        send_item(hsd_pkg::OP_DRAIN, 8'hff);
        // first tree byte under a zero total, then a large total before completion
        b = '0;
        for (int k = 7; k >= 0; k--) b[k] = tree_bits.pop_front();
        send_item(hsd_pkg::OP_BYTE, b);
        write_total(32'hffffffff);
        while (tree_bits.size() > 0) begin
            b = $urandom_range(255);
            for (int k = 7; k >= 0; k--)
                if (tree_bits.size() > 0) b[k] = tree_bits.pop_front();
            send_item(hsd_pkg::OP_BYTE, b);
        end
        send_item(hsd_pkg::OP_BYTE, 8'h00);
        send_item(hsd_pkg::OP_BYTE, 8'hff);
        send_item(hsd_pkg::OP_DRAIN, 8'h00);
        send_item(hsd_pkg::OP_BYTE, 8'haa);
        send_item(hsd_pkg::OP_BYTE, 8'h55);

        random_items(130);
        write_total(32'd100000);
        tx_idle_pct = 75; rx_idle_pct = 15;
        random_items(130);
        write_total(32'd200000);
        tx_idle_pct = 0; rx_idle_pct = 0;
        rx_hold = 400;
        random_items(130);
        // lowering the total below the count finishes the decode
        write_total(32'd1);
        random_items(10);
        write_total(32'hffffffff);
        random_items(5);

        wait_idle();
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/hsd_pkg.sv
rtl/hsd_ifs.sv
rtl/hsd_ram.sv
rtl/hsd_front.sv
rtl/hsd_back.sv
rtl/huffman_stream_decoder.sv
rtl/hsd_checker.sv
tb/huffman_stream_decoder_tb.sv
